### design/ifta_pkg.sv
package ifta_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int LEN_W  = 5;

    localparam logic [MODE_W-1:0] MODE_BYTE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVERRUN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    localparam logic [0:0] REG_IDLE_TICKS = 1'b0;

    localparam logic [BYTE_W-1:0] IDLE_TICKS_RESET = 8'd10;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

### design/ifta_if.sv
interface ifta_rx_if;
    logic                         valid;
    logic                         ready;
    logic [ifta_pkg::MODE_W-1:0]  mode;
    logic [ifta_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface ifta_frame_if;
    logic                         valid;
    logic                         ready;
    logic [ifta_pkg::BYTE_W-1:0]  frame_byte;
    logic [ifta_pkg::LEN_W-1:0]   frame_length;
    logic                         last;

    modport source (output valid, output frame_byte, output frame_length, output last,
                    input ready);
    modport sink (input valid, input frame_byte, input frame_length, input last,
                  output ready);
endinterface

### design/ifta_cell.sv
module ifta_cell
(
    input  logic                 clk,
    input  ifta_pkg::cell_ctl_t  ctl,
    input  ifta_pkg::byte_t      load_data,
    input  ifta_pkg::byte_t      shift_in,
    output ifta_pkg::byte_t      q
);

    ifta_pkg::byte_t data_reg;
    ifta_pkg::byte_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctl.load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### design/ifta_chain.sv
module ifta_chain
#(
    parameter int FRAME_BYTES = 16,
    parameter int FILL_W      = 5
)
(
    input  logic                 clk,
    input  logic                 load,
    input  logic                 shift,
    input  logic [FILL_W-1:0]    fill,
    input  ifta_pkg::byte_t      load_data,
    output ifta_pkg::byte_t      head
);

    ifta_pkg::byte_t q [FRAME_BYTES];

    genvar i;
    generate
        for (i = 0; i < FRAME_BYTES; i++)
        begin : g_cell
            ifta_pkg::cell_ctl_t ctl;
            ifta_pkg::byte_t     shift_in;

            assign ctl.load  = load && (fill == FILL_W'(i));
            assign ctl.shift = shift;

            if (i == FRAME_BYTES - 1)
            begin : g_tail
                assign shift_in = '0;
            end
            else
            begin : g_inner
                assign shift_in = q[i+1];
            end

            ifta_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .load_data (load_data),
                .shift_in  (shift_in),
                .q         (q[i])
            );
        end
    endgenerate

    assign head = q[0];

endmodule

### design/idle_timeout_frame_assembler.sv
// Collects received bytes into a row of FRAME_BYTES cells and closes the frame after
// idle_ticks poll ticks without a new byte (never while idle_ticks is zero). An input item
// (byte, overrun byte or poll tick) is taken whenever no frame is being sent out. The tick
// that closes a non-empty frame is followed by one output item per cycle while the output
// side is ready, frame length items in all, as the row of cells shifts its bytes toward
// the head; input is held off until the last item has been taken.
module idle_timeout_frame_assembler
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    ifta_rx_if.sink             rx,
    ifta_frame_if.source        frame,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);

    ifta_pkg::byte_t      idle_ticks_reg;
    ifta_pkg::byte_t      idle_ticks_next;
    ifta_pkg::byte_t      countdown_reg;
    ifta_pkg::byte_t      countdown_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    remain_reg;
    logic [FILL_W-1:0]    remain_next;
    logic [ifta_pkg::LEN_W-1:0] len_reg;
    logic [ifta_pkg::LEN_W-1:0] len_next;
    logic                 drain_reg;
    logic                 drain_next;

    logic                 rx_take;
    logic                 out_take;
    logic                 cell_load;
    logic                 cfg_write;
    ifta_pkg::byte_t      head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ifta_pkg::REG_IDLE_TICKS) ? {24'd0, idle_ticks_reg}
                                                               : 32'd0;

    assign rx.ready  = !drain_reg;
    assign rx_take   = rx.valid && rx.ready;
    assign out_take  = frame.valid && frame.ready;

    assign cell_load = rx_take && (rx.mode == ifta_pkg::MODE_BYTE)
                       && (fill_reg < FILL_W'(FRAME_BYTES));

    always_comb
    begin
        idle_ticks_next = idle_ticks_reg;
        if (cfg_write && (paddr[2] == ifta_pkg::REG_IDLE_TICKS))
        begin
            idle_ticks_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        countdown_next = countdown_reg;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        len_next       = len_reg;
        drain_next     = drain_reg;

        if (rx_take)
        begin
            unique case (rx.mode)
                ifta_pkg::MODE_BYTE:
                begin
                    countdown_next = idle_ticks_reg;
                    if (cell_load)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                ifta_pkg::MODE_TICK:
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - 1'b1;
                        if (countdown_reg == 8'd1)
                        begin
                            fill_next = '0;
                            if (fill_reg != '0)
                            begin
                                drain_next  = 1'b1;
                                remain_next = fill_reg;
                                len_next    = ifta_pkg::LEN_W'(fill_reg);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (out_take)
        begin
            remain_next = remain_reg - 1'b1;
            if (remain_reg == FILL_W'(1))
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg <= ifta_pkg::IDLE_TICKS_RESET;
            countdown_reg  <= '0;
            fill_reg       <= '0;
            remain_reg     <= '0;
            drain_reg      <= 1'b0;
        end
        else
        begin
            idle_ticks_reg <= idle_ticks_next;
            countdown_reg  <= countdown_next;
            fill_reg       <= fill_next;
            remain_reg     <= remain_next;
            drain_reg      <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    ifta_chain
    #(
        .FRAME_BYTES (FRAME_BYTES),
        .FILL_W      (FILL_W)
    )
    u_chain
    (
        .clk       (clk),
        .load      (cell_load),
        .shift     (out_take),
        .fill      (fill_reg),
        .load_data (rx.rx_byte),
        .head      (head)
    );

    assign frame.valid        = drain_reg;
    assign frame.frame_byte   = head;
    assign frame.frame_length = len_reg;
    assign frame.last         = (remain_reg == FILL_W'(1));

endmodule

### bench/tb_idle_timeout_frame_assembler.sv
`timescale 1ns / 1ps

module tb_idle_timeout_frame_assembler;

    localparam int FRAME_BYTES = 16;
    localparam logic [ifta_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] IDLE_TICKS_ADDR = {ifta_pkg::REG_IDLE_TICKS, 2'b00};
    localparam int SETTLE_CYCLES = FRAME_BYTES + 4;

    typedef struct packed {
        logic [ifta_pkg::MODE_W-1:0] mode;
        ifta_pkg::byte_t             data;
    } rx_item_t;

    typedef struct packed {
        ifta_pkg::byte_t            data;
        logic [ifta_pkg::LEN_W-1:0] length;
        logic                       last;
    } frame_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ifta_rx_if    rx_bus ();
    ifta_frame_if frame_bus ();

    idle_timeout_frame_assembler #(
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_bus),
        .frame   (frame_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rx_item_t    rx_pending[$];
    frame_beat_t expected_beats[$];

    ifta_pkg::byte_t stored_bytes[FRAME_BYTES];
    int              fill_level;
    ifta_pkg::byte_t countdown;
    ifta_pkg::byte_t idle_ticks_cfg;

    logic        rx_fired;
    int          send_gap;
    int          stall_left;
    bit          no_gaps;

    int          item_count;
    int          mismatch_count;
    int          bytes_taken;
    int          ticks_taken;
    int          frames_closed;
    int          beats_checked;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void assemble_frame(logic [ifta_pkg::MODE_W-1:0] mode,
                                           ifta_pkg::byte_t data);
        frame_beat_t beat;
        if (mode == ifta_pkg::MODE_BYTE)
        begin
            bytes_taken++;
            if (fill_level < FRAME_BYTES)
            begin
                stored_bytes[fill_level] = data;
                fill_level++;
            end
            countdown = idle_ticks_cfg;
        end
        else if (mode == ifta_pkg::MODE_TICK)
        begin
            ticks_taken++;
            if (countdown != 0)
            begin
                countdown--;
                if (countdown == 0)
                begin
                    for (int k = 0; k < fill_level; k++)
                    begin
                        beat.data   = stored_bytes[k];
                        beat.length = ifta_pkg::LEN_W'(fill_level);
                        beat.last   = (k + 1 == fill_level);
                        expected_beats.push_back(beat);
                    end
                    if (fill_level != 0)
                        frames_closed++;
                    fill_level = 0;
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        frame_beat_t want;
        rx_fired <= rx_bus.valid && rx_bus.ready;
        if (rst_n && frame_bus.valid && frame_bus.ready)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $error("frame item with nothing expected: byte %0h length %0d last %0b",
                       frame_bus.frame_byte, frame_bus.frame_length, frame_bus.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (frame_bus.frame_byte !== want.data)
                begin
                    $error("frame_byte: expected %0h, actual %0h", want.data,
                           frame_bus.frame_byte);
                    mismatch_count++;
                end
                if (frame_bus.frame_length !== want.length)
                begin
                    $error("frame_length: expected %0d, actual %0d", want.length,
                           frame_bus.frame_length);
                    mismatch_count++;
                end
                if (frame_bus.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, frame_bus.last);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && rx_bus.valid && rx_bus.ready)
            assemble_frame(rx_bus.mode, rx_bus.rx_byte);
    end

    always @(negedge clk)
    begin
        rx_item_t next_item;
        if (!rst_n)
        begin
            rx_bus.valid <= 1'b0;
        end
        else if (rx_bus.valid && !rx_fired)
        begin
            rx_bus.valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap     <= send_gap - 1;
            rx_bus.valid <= 1'b0;
        end
        else if (rx_pending.size() != 0)
        begin
            next_item      = rx_pending.pop_front();
            rx_bus.valid   <= 1'b1;
            rx_bus.mode    <= next_item.mode;
            rx_bus.rx_byte <= next_item.data;
            if (!no_gaps && $urandom_range(0, 7) == 0)
                send_gap <= $urandom_range(1, 17);
        end
        else
        begin
            rx_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frame_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            frame_bus.ready <= 1'b0;
        end
        else if (!no_gaps && $urandom_range(0, 9) == 0)
        begin
            stall_left      <= $urandom_range(0, 16);
            frame_bus.ready <= 1'b0;
        end
        else
        begin
            frame_bus.ready <= 1'b1;
        end
    end

    task automatic push_item(input logic [ifta_pkg::MODE_W-1:0] mode,
                             input ifta_pkg::byte_t data);
        rx_item_t item;
        item.mode = mode;
        item.data = data;
        rx_pending.push_back(item);
        if (mode != MODE_UNUSED)
            item_count++;
    endtask

    task automatic drain();
        @(posedge clk);
        while (rx_pending.size() != 0 || rx_bus.valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_idle_ticks(input ifta_pkg::byte_t value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= IDLE_TICKS_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        idle_ticks_cfg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(value))
        begin
            $error("idle_ticks readback: expected %0d, actual %0d", value, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_frame();
        int nbytes;
        int closing;
        nbytes = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        for (int k = 0; k < nbytes; k++)
        begin
            push_item(ifta_pkg::MODE_BYTE, ifta_pkg::byte_t'($urandom));
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_item(ifta_pkg::MODE_OVERRUN, ifta_pkg::byte_t'($urandom));
                    1: push_item(MODE_UNUSED, ifta_pkg::byte_t'($urandom));
                    default:
                    begin
                        if (idle_ticks_cfg > 1)
                            repeat ($urandom_range(1, idle_ticks_cfg - 1))
                                push_item(ifta_pkg::MODE_TICK, ifta_pkg::byte_t'($urandom));
                    end
                endcase
            end
        end
        closing = int'(idle_ticks_cfg);
        if ($urandom_range(0, 7) == 0)
            closing = $urandom_range(0, idle_ticks_cfg - 1);
        else if ($urandom_range(0, 3) == 0)
            closing = closing + $urandom_range(1, 3);
        repeat (closing)
            push_item(ifta_pkg::MODE_TICK, ifta_pkg::byte_t'($urandom));
    endtask

    initial
    begin
        int random_start;
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rx_bus.valid    = 1'b0;
        rx_bus.mode     = ifta_pkg::MODE_BYTE;
        rx_bus.rx_byte  = '0;
        frame_bus.ready = 1'b0;
        rx_fired        = 1'b0;
        send_gap        = 0;
        stall_left      = 0;
        no_gaps         = 1'b0;
        item_count      = 0;
        mismatch_count  = 0;
        bytes_taken     = 0;
        ticks_taken     = 0;
        frames_closed   = 0;
        beats_checked   = 0;
        fill_level      = 0;
        countdown       = '0;
        idle_ticks_cfg  = ifta_pkg::IDLE_TICKS_RESET;
        foreach (stored_bytes[k])
            stored_bytes[k] = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        push_item(ifta_pkg::MODE_TICK, 8'h00);
        push_item(ifta_pkg::MODE_BYTE, 8'h00);
        push_item(ifta_pkg::MODE_BYTE, 8'hFF);
        push_item(ifta_pkg::MODE_OVERRUN, 8'hA5);
        push_item(MODE_UNUSED, 8'h3C);
        repeat (ifta_pkg::IDLE_TICKS_RESET)
            push_item(ifta_pkg::MODE_TICK, 8'hFF);

        program_idle_ticks(8'd1);
        for (int k = 0; k < FRAME_BYTES + 4; k++)
            push_item(ifta_pkg::MODE_BYTE, ifta_pkg::byte_t'(8'h10 + k));
        push_item(ifta_pkg::MODE_TICK, 8'h00);

        program_idle_ticks(8'd0);
        push_item(ifta_pkg::MODE_BYTE, 8'h5A);
        push_item(ifta_pkg::MODE_BYTE, 8'hC3);
        repeat (4)
            push_item(ifta_pkg::MODE_TICK, 8'h00);

        program_idle_ticks(8'd255);
        push_item(ifta_pkg::MODE_BYTE, ifta_pkg::byte_t'($urandom));
        repeat (4)
            push_item(ifta_pkg::MODE_TICK, ifta_pkg::byte_t'($urandom));

        random_start = item_count;
        program_idle_ticks(8'd1);
        while (item_count - random_start < 30)
            queue_frame();
        program_idle_ticks(ifta_pkg::byte_t'($urandom_range(2, 12)));
        while (item_count - random_start < 90)
            queue_frame();
        program_idle_ticks(8'd3);
        no_gaps = 1'b1;
        while (item_count - random_start < 130)
            queue_frame();

        drain();
        $display("Sent %0d bytes and %0d poll ticks; %0d frames closed, %0d frame items checked.",
                 bytes_taken, ticks_taken, frames_closed, beats_checked);
        $display("idle_ticks went through 10, 1, 0, 255 and random values.");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
design/ifta_pkg.sv
design/ifta_if.sv
design/ifta_cell.sv
design/ifta_chain.sv
design/idle_timeout_frame_assembler.sv
bench/tb_idle_timeout_frame_assembler.sv
